/* rtl/core/assert_macros.svh */
// Assertion macros used by the top level of the membrane boundary core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

/* rtl/core/mbr_pkg.sv */
// Constants, register indexes and saturation helpers of the membrane boundary core.
`default_nettype none

package mbr_pkg;

   localparam int MAX_SEGMENTS = 1024;
   localparam int POLE_NUM     = 2;
   // One segment is 1000.0 length units, in Q20.12.
   localparam int SEG_STEP     = 4096000;
   localparam int FORCE_GAIN   = 10;
   localparam int AXIS_RESET   = 4096;
   localparam int RADIUS_RESET = 4096;

   typedef enum logic [2:0] {
      CSR_SHAPE_MODE  = 3'd0,
      CSR_AXIS_A      = 3'd1,
      CSR_AXIS_B      = 3'd2,
      CSR_AXIS_C      = 3'd3,
      CSR_TUBE_RADIUS = 3'd4
   } csr_index_type;

   function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
      logic signed [31:0] res;
      if (!v[34] && (v[33:31] != 3'b000)) begin
         res = 32'sh7fffffff;
      end else if (v[34] && (v[33:31] != 3'b111)) begin
         res = 32'sh80000000;
      end else begin
         res = v[31:0];
      end
      return res;
   endfunction

   // Clamps a magnitude to the positive 32-bit range and applies a sign.
   function automatic logic signed [31:0] sat_sign(input logic [63:0] m, input logic neg);
      logic [31:0] s;
      s = (m > 64'h7fffffff) ? 32'h7fffffff : m[31:0];
      return neg ? -s : s;
   endfunction

endpackage

`default_nettype wire

/* rtl/core/mbr_div.sv */
// Pipelined restoring divider, one quotient bit per stage, all ones on overflow.
`default_nettype none

module mbr_div #(
   parameter int NUM_W = 48,
   parameter int DEN_W = 31,
   parameter int Q_W   = 27
) (
   input  wire logic             clock,
   input  wire logic [NUM_W-1:0] num,
   input  wire logic [DEN_W-1:0] den,
   output logic      [Q_W-1:0]   quot
);

   localparam int W = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

   logic [W-1:0]     rem_ff  [Q_W];
   logic [W-1:0]     rem_in  [Q_W];
   logic [DEN_W-1:0] den_ff  [Q_W];
   logic [Q_W-1:0]   quot_ff [Q_W];
   logic [Q_W-1:0]   quot_in [Q_W];
   logic             ovf_ff  [Q_W];

   for (genvar j = 0; j < Q_W; j++) begin : g_stage
      logic [W-1:0]     rem_prev;
      logic [DEN_W-1:0] den_prev;
      logic [Q_W-1:0]   quot_prev;
      logic             ovf_prev;
      logic [W-1:0]     trial;

      if (j == 0) begin : g_first
         assign rem_prev  = W'(num);
         assign den_prev  = den;
         assign quot_prev = '0;
         // The quotient does not fit in Q_W bits.
         assign ovf_prev  = W'(num) >= (W'(den) << Q_W);
      end else begin : g_next
         assign rem_prev  = rem_ff[j-1];
         assign den_prev  = den_ff[j-1];
         assign quot_prev = quot_ff[j-1];
         assign ovf_prev  = ovf_ff[j-1];
      end

      assign trial = W'(den_prev) << (Q_W - 1 - j);

      always_comb begin
         if (rem_prev >= trial) begin
            rem_in[j]  = rem_prev - trial;
            quot_in[j] = quot_prev | (Q_W'(1) << (Q_W - 1 - j));
         end else begin
            rem_in[j]  = rem_prev;
            quot_in[j] = quot_prev;
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[j]  <= rem_in[j];
         den_ff[j]  <= den_prev;
         quot_ff[j] <= quot_in[j];
         ovf_ff[j]  <= ovf_prev;
      end
   end

   assign quot = ovf_ff[Q_W-1] ? '1 : quot_ff[Q_W-1];

endmodule

`default_nettype wire

/* rtl/core/mbr_sqrt.sv */
// Pipelined integer square root, one root bit per stage.
`default_nettype none

module mbr_sqrt #(
   parameter int IN_W = 64
) (
   input  wire logic              clock,
   input  wire logic [IN_W-1:0]   radicand,
   output logic      [IN_W/2-1:0] root
);

   localparam int OUT_W = IN_W / 2;

   logic [IN_W-1:0] v_ff [OUT_W];
   logic [IN_W-1:0] v_in [OUT_W];
   logic [IN_W-1:0] r_ff [OUT_W];
   logic [IN_W-1:0] r_in [OUT_W];

   for (genvar j = 0; j < OUT_W; j++) begin : g_stage
      logic [IN_W-1:0] v_prev;
      logic [IN_W-1:0] r_prev;
      logic [IN_W:0]   bit_w;
      logic [IN_W:0]   trial;

      if (j == 0) begin : g_first
         assign v_prev = radicand;
         assign r_prev = '0;
      end else begin : g_next
         assign v_prev = v_ff[j-1];
         assign r_prev = r_ff[j-1];
      end

      assign bit_w = (IN_W + 1)'(1) << (2 * (OUT_W - 1 - j));
      assign trial = {1'b0, r_prev} + bit_w;

      always_comb begin
         if ({1'b0, v_prev} >= trial) begin
            v_in[j] = IN_W'({1'b0, v_prev} - trial);
            r_in[j] = IN_W'(({1'b0, r_prev} >> 1) + bit_w);
         end else begin
            v_in[j] = v_prev;
            r_in[j] = r_prev >> 1;
         end
      end

      always_ff @(posedge clock) begin
         v_ff[j] <= v_in[j];
         r_ff[j] <= r_in[j];
      end
   end

   assign root = r_ff[OUT_W-1][OUT_W-1:0];

endmodule

`default_nettype wire

/* rtl/core/membrane_boundary_retract_core.sv */
// Top level of the membrane boundary test and filament retraction pipeline.
// The core accepts one filament per clock cycle and never raises busy. Each
// transaction returns exactly one result, strobed by rsp_valid for one cycle;
// results leave in acceptance order and the receiver cannot stall them. The
// pipeline depth is set by the longest chain: a 32-stage square root for the
// segment length followed by a 32-stage divider for the shift. Configuration
// writes are taken at once (csr_ready is always high) and are meant to happen
// while no transaction is in flight.
`default_nettype none

module membrane_boundary_retract_core (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic signed [31:0] req_tip_x,
   input  wire logic signed [31:0] req_tip_y,
   input  wire logic signed [31:0] req_tip_z,
   input  wire logic signed [31:0] req_prior_x,
   input  wire logic signed [31:0] req_prior_y,
   input  wire logic signed [31:0] req_prior_z,
   input  wire logic               req_shrinking,
   input  wire logic signed [31:0] req_filament_length,
   input  wire logic        [9:0]  req_segment_index,
   input  wire logic               req_pole_index,
   output logic                    rsp_valid,
   output logic                    rsp_crossed,
   output logic signed      [31:0] rsp_shift_x,
   output logic signed      [31:0] rsp_shift_y,
   output logic signed      [31:0] rsp_shift_z,
   output logic signed      [31:0] rsp_new_length,
   output logic signed      [31:0] rsp_prior_length_value,
   output logic signed      [31:0] rsp_force_x,
   output logic signed      [31:0] rsp_force_y,
   output logic signed      [31:0] rsp_force_z,
   output logic                    rsp_pole_out,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic        [2:0]  csr_index,
   input  wire logic        [31:0] csr_wdata
);

`include "assert_macros.svh"

   localparam int ST_PREP  = 1;
   localparam int ST_SQ    = ST_PREP + 1;
   localparam int ST_SUM   = ST_SQ + 1;
   localparam int QA_W     = 27;
   localparam int ST_QA    = ST_PREP + QA_W;
   localparam int ST_QSQ   = ST_QA + 1;
   localparam int ST_RE2   = ST_QSQ + 1;
   localparam int ST_CROSS = ST_RE2 + 1;
   localparam int RT_IN    = 64;
   localparam int ST_ROOT  = ST_SUM + RT_IN / 2;
   localparam int QU_W     = 17;
   localparam int ST_U     = ST_ROOT + QU_W;
   localparam int ST_FM    = ST_U + 1;
   localparam int ST_FORCE = ST_FM + 1;
   localparam int ST_PROD  = ST_ROOT + 1;
   localparam int QS_W     = 32;
   localparam int ST_LAST  = ST_PROD + QS_W;

   typedef struct packed {
      logic signed [2:0][31:0] tip;
      logic signed [2:0][31:0] prior;
      logic signed [31:0]      len;
      logic        [9:0]       seg;
      logic                    pole;
      logic                    shrink;
   } in_type;

   // Everything that rides along the pipeline beside the arithmetic units.
   typedef struct packed {
      logic               valid;
      logic               pole;
      logic               shrink;
      logic               box_out;
      logic [2:0]         rneg;
      logic [2:0]         dneg;
      logic [2:0][31:0]   absr;
      logic [2:0][31:0]   h;
      logic signed [31:0] nlen;
      logic [31:0]        segoff;
      logic signed [31:0] plen;
      logic               crossed;
      logic [37:0]        e10;
      logic               lzero;
      logic               rlzero;
      logic [2:0][31:0]   force_v;
   } side_type;

   logic        shape_mode_ff;
   logic [30:0] axis_a_ff;
   logic [30:0] axis_b_ff;
   logic [30:0] axis_c_ff;
   logic [30:0] tube_radius_ff;

   in_type   in_ff;
   logic     in_valid_ff;
   side_type side_ff [ST_PREP:ST_LAST];
   side_type side_in [ST_PREP:ST_LAST];

   logic [2:0][30:0] axis_nz;
   logic [31:0]      twor;

   logic [63:0]      r2_ff [3];
   logic [63:0]      h2_ff [3];
   logic [63:0]      sq_ff;
   logic [63:0]      hs_ff;
   logic [QA_W-1:0]  qa [3];
   logic [53:0]      qsq_ff [3];
   logic [53:0]      re2_ff;
   logic [31:0]      rl;
   logic [31:0]      lseg;
   logic [31:0]      lseg_ff;
   logic [QU_W-1:0]  u [3];
   logic [54:0]      fm_ff [3];
   logic [63:0]      prod_ff [3];
   logic [QS_W-1:0]  qs [3];

   logic               out_valid_ff;
   logic               out_crossed_ff;
   logic signed [31:0] out_shift_ff [3];
   logic signed [31:0] out_nlen_ff;
   logic signed [31:0] out_plen_ff;
   logic signed [31:0] out_force_ff [3];
   logic               out_pole_ff;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         shape_mode_ff  <= 1'b0;
         axis_a_ff      <= 31'(mbr_pkg::AXIS_RESET);
         axis_b_ff      <= 31'(mbr_pkg::AXIS_RESET);
         axis_c_ff      <= 31'(mbr_pkg::AXIS_RESET);
         tube_radius_ff <= 31'(mbr_pkg::RADIUS_RESET);
      end else if (csr_valid && csr_ready) begin
         case (mbr_pkg::csr_index_type'(csr_index))
            mbr_pkg::CSR_SHAPE_MODE:  shape_mode_ff  <= csr_wdata[0];
            mbr_pkg::CSR_AXIS_A:      axis_a_ff      <= csr_wdata[30:0];
            mbr_pkg::CSR_AXIS_B:      axis_b_ff      <= csr_wdata[30:0];
            mbr_pkg::CSR_AXIS_C:      axis_c_ff      <= csr_wdata[30:0];
            mbr_pkg::CSR_TUBE_RADIUS: tube_radius_ff <= csr_wdata[30:0];
            default: ;
         endcase
      end
   end

   // A zero extent behaves as the smallest nonzero one.
   assign axis_nz[0] = (axis_a_ff == '0) ? 31'd1 : axis_a_ff;
   assign axis_nz[1] = (axis_b_ff == '0) ? 31'd1 : axis_b_ff;
   assign axis_nz[2] = (axis_c_ff == '0) ? 31'd1 : axis_c_ff;
   assign twor       = {tube_radius_ff, 1'b0};

   // Input capture.
   always_ff @(posedge clock) begin
      in_ff.tip[0] <= req_tip_x;
      in_ff.tip[1] <= req_tip_y;
      in_ff.tip[2] <= req_tip_z;
      in_ff.prior[0] <= req_prior_x;
      in_ff.prior[1] <= req_prior_y;
      in_ff.prior[2] <= req_prior_z;
      in_ff.len    <= req_filament_length;
      in_ff.seg    <= req_segment_index;
      in_ff.pole   <= req_pole_index;
      in_ff.shrink <= req_shrinking;
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= start && !busy;
      end
   end

   // Sideband pipeline with the values injected at the stages that make them.
   always_comb begin
      logic signed [32:0] r33;
      logic        [32:0] rabs;
      logic signed [33:0] d34;
      logic        [33:0] dabs;
      logic signed [34:0] c2;
      logic signed [34:0] a35;
      logic signed [34:0] n35;
      logic        [9:0]  segc;
      logic        [53:0] diff;
      logic        [33:0] e;

      for (int k = ST_PREP + 1; k <= ST_LAST; k++) begin
         side_in[k] = side_ff[k-1];
      end

      side_in[ST_PREP]         = '0;
      side_in[ST_PREP].valid   = in_valid_ff;
      side_in[ST_PREP].shrink  = in_ff.shrink;
      side_in[ST_PREP].pole    = (32'(in_ff.pole) >= mbr_pkg::POLE_NUM) ?
                                 1'(mbr_pkg::POLE_NUM - 1) : in_ff.pole;
      for (int i = 0; i < 3; i++) begin
         // Elements of a packed array are unsigned, so the sign is restored here.
         r33  = 33'($signed(in_ff.tip[i]));
         rabs = r33[32] ? 33'(-r33) : 33'(r33);
         d34  = 34'($signed(in_ff.tip[i])) - 34'($signed(in_ff.prior[i]));
         dabs = d34[33] ? 34'(-d34) : 34'(d34);
         c2   = {{2{in_ff.tip[i][31]}}, in_ff.tip[i], 1'b0};
         a35  = 35'({4'b0000, axis_nz[i]});
         side_in[ST_PREP].absr[i] = rabs[31:0];
         side_in[ST_PREP].rneg[i] = in_ff.tip[i][31];
         side_in[ST_PREP].h[i]    = dabs[32:1];
         side_in[ST_PREP].dneg[i] = d34[33];
         if ((c2 > a35) || (c2 < -a35)) begin
            side_in[ST_PREP].box_out = 1'b1;
         end
      end
      n35 = 35'(in_ff.len) - 35'({3'b000, twor});
      side_in[ST_PREP].nlen = mbr_pkg::sat32(n35);
      segc = ({7'b0, in_ff.seg} >= 17'(mbr_pkg::MAX_SEGMENTS)) ?
             10'(mbr_pkg::MAX_SEGMENTS - 1) : in_ff.seg;
      if (segc == '0) begin
         segc = 10'd1;
      end
      side_in[ST_PREP].segoff = 32'(segc - 10'd1) * 32'(mbr_pkg::SEG_STEP);

      side_in[ST_SQ].plen = mbr_pkg::sat32(35'(side_ff[ST_SQ-1].nlen) -
                                           35'({3'b000, side_ff[ST_SQ-1].segoff}));

      side_in[ST_CROSS].crossed = !side_ff[ST_CROSS-1].shrink &&
         (shape_mode_ff ? side_ff[ST_CROSS-1].box_out : (re2_ff > (54'(1) << 32)));
      // Excess of the ellipsoid measure over one, in Q12, times the gain.
      diff = re2_ff - (54'(1) << 32);
      e    = diff[53:20];
      side_in[ST_CROSS].e10 = 38'(e) * 38'(mbr_pkg::FORCE_GAIN);

      // The roots belong to the transaction sitting in stage ST_ROOT.
      side_in[ST_ROOT + 1].lzero  = (lseg == '0);
      side_in[ST_ROOT + 1].rlzero = (rl == '0);

      for (int i = 0; i < 3; i++) begin
         side_in[ST_FORCE].force_v[i] = mbr_pkg::sat_sign(64'(fm_ff[i] >> 16),
                                                          side_ff[ST_FORCE-1].rneg[i]);
      end
   end

   always_ff @(posedge clock) begin
      for (int k = ST_PREP; k <= ST_LAST; k++) begin
         if (reset) begin
            side_ff[k] <= '0;
         end else begin
            side_ff[k] <= side_in[k];
         end
      end
   end

   // Squares and their sums.
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         r2_ff[i] <= 64'(side_ff[ST_SQ-1].absr[i]) * 64'(side_ff[ST_SQ-1].absr[i]);
         h2_ff[i] <= 64'(side_ff[ST_SQ-1].h[i]) * 64'(side_ff[ST_SQ-1].h[i]);
      end
      sq_ff <= r2_ff[0] + r2_ff[1] + r2_ff[2];
      hs_ff <= h2_ff[0] + h2_ff[1] + h2_ff[2];
   end

   mbr_sqrt #(.IN_W(RT_IN)) u_root_r (
      .clock    (clock),
      .radicand (sq_ff),
      .root     (rl)
   );

   mbr_sqrt #(.IN_W(RT_IN)) u_root_l (
      .clock    (clock),
      .radicand (hs_ff),
      .root     (lseg)
   );

   for (genvar i = 0; i < 3; i++) begin : g_axis
      logic [QA_W-1:0] qcap;

      // Coordinate over extent in Q16.
      mbr_div #(.NUM_W(48), .DEN_W(31), .Q_W(QA_W)) u_div_ratio (
         .clock (clock),
         .num   ({side_ff[ST_PREP].absr[i], 16'h0000}),
         .den   (axis_nz[i]),
         .quot  (qa[i])
      );

      assign qcap = (qa[i] > (QA_W'(1) << 26)) ? (QA_W'(1) << 26) : qa[i];

      always_ff @(posedge clock) begin
         qsq_ff[i] <= 54'(qcap) * 54'(qcap);
      end

      // Unit vector component of the tip in Q16.
      mbr_div #(.NUM_W(48), .DEN_W(32), .Q_W(QU_W)) u_div_unit (
         .clock (clock),
         .num   ({side_ff[ST_ROOT].absr[i], 16'h0000}),
         .den   (rl),
         .quot  (u[i])
      );

      always_ff @(posedge clock) begin
         fm_ff[i]   <= 55'(side_ff[ST_FM-1].e10) * 55'(u[i]);
         prod_ff[i] <= 64'(twor) * 64'(side_ff[ST_PROD-1].h[i]);
      end

      mbr_div #(.NUM_W(64), .DEN_W(32), .Q_W(QS_W)) u_div_shift (
         .clock (clock),
         .num   (prod_ff[i]),
         .den   (lseg_ff),
         .quot  (qs[i])
      );
   end

   always_ff @(posedge clock) begin
      re2_ff  <= qsq_ff[0] + qsq_ff[1] + qsq_ff[2];
      lseg_ff <= lseg;
   end

   // Result register.
   always_ff @(posedge clock) begin
      out_crossed_ff <= side_ff[ST_LAST].crossed;
      out_pole_ff    <= side_ff[ST_LAST].pole;
      out_nlen_ff    <= side_ff[ST_LAST].crossed ? side_ff[ST_LAST].nlen : '0;
      out_plen_ff    <= side_ff[ST_LAST].crossed ? side_ff[ST_LAST].plen : '0;
      for (int i = 0; i < 3; i++) begin
         if (side_ff[ST_LAST].crossed && !side_ff[ST_LAST].lzero) begin
            out_shift_ff[i] <= mbr_pkg::sat_sign(64'(qs[i]), side_ff[ST_LAST].dneg[i]);
         end else begin
            out_shift_ff[i] <= '0;
         end
         if (side_ff[ST_LAST].crossed && !shape_mode_ff && !side_ff[ST_LAST].rlzero) begin
            out_force_ff[i] <= side_ff[ST_LAST].force_v[i];
         end else begin
            out_force_ff[i] <= '0;
         end
      end
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= side_ff[ST_LAST].valid;
      end
   end

   assign rsp_valid              = out_valid_ff;
   assign rsp_crossed            = out_crossed_ff;
   assign rsp_shift_x            = out_shift_ff[0];
   assign rsp_shift_y            = out_shift_ff[1];
   assign rsp_shift_z            = out_shift_ff[2];
   assign rsp_new_length         = out_nlen_ff;
   assign rsp_prior_length_value = out_plen_ff;
   assign rsp_force_x            = out_force_ff[0];
   assign rsp_force_y            = out_force_ff[1];
   assign rsp_force_z            = out_force_ff[2];
   assign rsp_pole_out           = out_pole_ff;

   `ASSERT_NXT(a_accept_enters, clock, reset, start && !busy, in_valid_ff)
   `ASSERT_IMP(a_quiet_result, clock, reset, rsp_valid && !rsp_crossed, rsp_shift_x == 0 && rsp_new_length == 0 && rsp_force_x == 0 && rsp_prior_length_value == 0)
   `ASSERT_IMP(a_box_no_force, clock, reset, rsp_valid && shape_mode_ff, rsp_force_x == 0 && rsp_force_y == 0 && rsp_force_z == 0)

endmodule

`default_nettype wire

/* sim/membrane_boundary_retract_core_tb.sv */
// Self-checking testbench of the membrane boundary test and retraction core.
`timescale 1ns / 1ps

module membrane_boundary_retract_core_tb;

   typedef struct packed {
      logic [2:0][31:0] tip;
      logic [2:0][31:0] prior;
      logic             shrinking;
      logic [31:0]      length;
      logic [9:0]       seg;
      logic             pole;
   } filament_type;

   typedef struct packed {
      logic             crossed;
      logic [2:0][31:0] shift;
      logic [31:0]      new_length;
      logic [31:0]      prior_length;
      logic [2:0][31:0] force_v;
      logic             pole;
   } retract_type;

   localparam int LATENCY_WAIT = 100;
   localparam int STALL_LIMIT  = 3000;

   logic clock, reset, start, busy;
   logic signed [31:0] req_tip_x, req_tip_y, req_tip_z;
   logic signed [31:0] req_prior_x, req_prior_y, req_prior_z;
   logic               req_shrinking;
   logic signed [31:0] req_filament_length;
   logic [9:0]         req_segment_index;
   logic               req_pole_index;
   logic               rsp_valid, rsp_crossed, rsp_pole_out;
   logic signed [31:0] rsp_shift_x, rsp_shift_y, rsp_shift_z;
   logic signed [31:0] rsp_new_length, rsp_prior_length_value;
   logic signed [31:0] rsp_force_x, rsp_force_y, rsp_force_z;
   logic               csr_valid, csr_ready;
   logic [2:0]         csr_index;
   logic [31:0]        csr_wdata;

   membrane_boundary_retract_core u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_tip_x(req_tip_x), .req_tip_y(req_tip_y), .req_tip_z(req_tip_z),
      .req_prior_x(req_prior_x), .req_prior_y(req_prior_y), .req_prior_z(req_prior_z),
      .req_shrinking(req_shrinking), .req_filament_length(req_filament_length),
      .req_segment_index(req_segment_index), .req_pole_index(req_pole_index),
      .rsp_valid(rsp_valid), .rsp_crossed(rsp_crossed),
      .rsp_shift_x(rsp_shift_x), .rsp_shift_y(rsp_shift_y), .rsp_shift_z(rsp_shift_z),
      .rsp_new_length(rsp_new_length), .rsp_prior_length_value(rsp_prior_length_value),
      .rsp_force_x(rsp_force_x), .rsp_force_y(rsp_force_y), .rsp_force_z(rsp_force_z),
      .rsp_pole_out(rsp_pole_out),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // Predictor copy of the configuration registers.
   logic        cfg_box;
   logic [30:0] cfg_axis [3];
   logic [30:0] cfg_radius;

   filament_type filament_feed [$];
   retract_type  expected_retracts [$];
   filament_type on_port;
   bit           calm;
   int           fail_count;
   int           stall_cycles;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic logic [63:0] magnitude(input longint v);
      return (v < 0) ? 64'(-v) : 64'(v);
   endfunction

   function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
      logic [63:0] root, bit_w;
      root = 0;
      bit_w = 64'h1 << 62;
      while (bit_w > v) bit_w = bit_w >> 2;
      while (bit_w != 0) begin
         if (v >= root + bit_w) begin
            v = v - (root + bit_w);
            root = (root >> 1) + bit_w;
         end else begin
            root = root >> 1;
         end
         bit_w = bit_w >> 2;
      end
      return root;
   endfunction

   function automatic logic [31:0] signed_clamp(input logic [63:0] m, input bit neg);
      logic [31:0] s;
      s = (m > 64'h7fffffff) ? 32'h7fffffff : m[31:0];
      return neg ? -s : s;
   endfunction

   function automatic longint clamp32(input longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic retract_type retract_predict(input filament_type f);
      retract_type o;
      logic [63:0] ax [3];
      logic [63:0] h [3];
      logic [63:0] re2, hs, seg_len, twor, sq, rl, e, u, q, m;
      longint      r [3];
      longint      d [3];
      longint      nl, seg, a;
      bit          crossed;
      o = '0;
      re2 = 0;
      hs = 0;
      sq = 0;
      crossed = 0;
      seg = (f.seg == 0) ? 1 : f.seg;
      for (int i = 0; i < 3; i++) begin
         ax[i] = (cfg_axis[i] == 0) ? 64'd1 : 64'(cfg_axis[i]);
         r[i] = longint'($signed(f.tip[i]));
      end
      if (!f.shrinking) begin
         for (int i = 0; i < 3; i++) begin
            if (!cfg_box) begin
               q = (magnitude(r[i]) << 16) / ax[i];
               if (q > (64'h1 << 26)) q = 64'h1 << 26;
               re2 = re2 + q * q;
            end else begin
               a = longint'(ax[i]);
               if (2 * r[i] > a || 2 * r[i] < -a) crossed = 1;
            end
         end
         if (!cfg_box) crossed = re2 > 64'h1_0000_0000;
      end
      if (crossed) begin
         for (int i = 0; i < 3; i++) begin
            d[i] = r[i] - longint'($signed(f.prior[i]));
            h[i] = magnitude(d[i]) >> 1;
            hs = hs + h[i] * h[i];
         end
         seg_len = floor_sqrt(hs);
         twor = 2 * 64'(cfg_radius);
         // A segment no longer than one LSB per axis gives no direction.
         if (seg_len != 0)
            for (int i = 0; i < 3; i++)
               o.shift[i] = signed_clamp(twor * h[i] / seg_len, d[i] < 0);
         nl = clamp32(longint'($signed(f.length)) - longint'(twor));
         o.new_length = nl[31:0];
         o.prior_length = 32'(clamp32(nl - (seg - 1) * mbr_pkg::SEG_STEP));
         if (!cfg_box) begin
            for (int i = 0; i < 3; i++) begin
               m = magnitude(r[i]);
               sq = sq + m * m;
            end
            rl = floor_sqrt(sq);
            e = (re2 - 64'h1_0000_0000) >> 20;
            if (rl != 0)
               for (int i = 0; i < 3; i++) begin
                  u = (magnitude(r[i]) << 16) / rl;
                  o.force_v[i] = signed_clamp((mbr_pkg::FORCE_GAIN * e * u) >> 16,
                                              r[i] < 0);
               end
         end
      end
      o.crossed = crossed;
      o.pole = f.pole;
      return o;
   endfunction

   // Driver: after the previous filament was taken, a new one may go out; always if calm is set.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) expected_retracts.push_back(retract_predict(on_port));
         if (!start || !busy) begin
            if (filament_feed.size() != 0 && (calm || $urandom_range(0, 99) >= 19)) begin
               on_port = filament_feed.pop_front();
               start <= 1'b1;
               req_tip_x <= on_port.tip[0];
               req_tip_y <= on_port.tip[1];
               req_tip_z <= on_port.tip[2];
               req_prior_x <= on_port.prior[0];
               req_prior_y <= on_port.prior[1];
               req_prior_z <= on_port.prior[2];
               req_shrinking <= on_port.shrinking;
               req_filament_length <= on_port.length;
               req_segment_index <= on_port.seg;
               req_pole_index <= on_port.pole;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Monitor: every strobed result is matched against the oldest expectation.
   always @(posedge clock) begin
      retract_type exp_r;
      if (!reset && rsp_valid) begin
         if (expected_retracts.size() == 0) begin
            $error("result with no transaction outstanding");
            fail_count++;
         end else begin
            exp_r = expected_retracts.pop_front();
            if (rsp_crossed !== exp_r.crossed) begin
               $error("crossed exp %0d got %0d", exp_r.crossed, rsp_crossed); fail_count++;
            end
            if (rsp_shift_x !== exp_r.shift[0]) begin
               $error("shift_x exp %0d got %0d", $signed(exp_r.shift[0]), rsp_shift_x);
               fail_count++;
            end
            if (rsp_shift_y !== exp_r.shift[1]) begin
               $error("shift_y exp %0d got %0d", $signed(exp_r.shift[1]), rsp_shift_y);
               fail_count++;
            end
            if (rsp_shift_z !== exp_r.shift[2]) begin
               $error("shift_z exp %0d got %0d", $signed(exp_r.shift[2]), rsp_shift_z);
               fail_count++;
            end
            if (rsp_new_length !== exp_r.new_length) begin
               $error("new_length exp %0d got %0d", $signed(exp_r.new_length),
                      rsp_new_length);
               fail_count++;
            end
            if (rsp_prior_length_value !== exp_r.prior_length) begin
               $error("prior_length_value exp %0d got %0d", $signed(exp_r.prior_length),
                      rsp_prior_length_value);
               fail_count++;
            end
            if (rsp_force_x !== exp_r.force_v[0]) begin
               $error("force_x exp %0d got %0d", $signed(exp_r.force_v[0]), rsp_force_x);
               fail_count++;
            end
            if (rsp_force_y !== exp_r.force_v[1]) begin
               $error("force_y exp %0d got %0d", $signed(exp_r.force_v[1]), rsp_force_y);
               fail_count++;
            end
            if (rsp_force_z !== exp_r.force_v[2]) begin
               $error("force_z exp %0d got %0d", $signed(exp_r.force_v[2]), rsp_force_z);
               fail_count++;
            end
            if (rsp_pole_out !== exp_r.pole) begin
               $error("pole_out exp %0d got %0d", exp_r.pole, rsp_pole_out); fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("membrane_boundary_retract_core_tb NOT OK");
         $finish;
      end
   end

   task automatic write_reg(input mbr_pkg::csr_index_type idx, input logic [31:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         mbr_pkg::CSR_SHAPE_MODE:  cfg_box = val[0];
         mbr_pkg::CSR_AXIS_A:      cfg_axis[0] = val[30:0];
         mbr_pkg::CSR_AXIS_B:      cfg_axis[1] = val[30:0];
         mbr_pkg::CSR_AXIS_C:      cfg_axis[2] = val[30:0];
         mbr_pkg::CSR_TUBE_RADIUS: cfg_radius = val[30:0];
         default: ;
      endcase
      csr_valid <= 1'b0;
   endtask

   task automatic drain;
      do @(negedge clock);
      while (filament_feed.size() != 0 || expected_retracts.size() != 0 || start);
      repeat (LATENCY_WAIT) @(negedge clock);
   endtask

   // Coordinate within 2 * extent + 2 of the origin most of the time, anything at all otherwise.
   function automatic logic [31:0] pick_coord(input logic [30:0] axv);
      longint span, v;
      if ($urandom_range(0, 3) == 0) return $urandom;
      span = 2 * longint'(axv) + 2;
      if (span > 64'sd2147483647) span = 64'sd2147483647;
      v = longint'($urandom_range(0, 32'(span)));
      return $urandom_range(0, 1) ? 32'(-v) : 32'(v);
   endfunction

   function automatic filament_type random_filament();
      filament_type f;
      logic [31:0] off;
      for (int i = 0; i < 3; i++) begin
         f.tip[i] = pick_coord(cfg_axis[i]);
         case ($urandom_range(0, 5))
            0: f.prior[i] = $urandom;
            1: f.prior[i] = f.tip[i] + 32'($urandom_range(0, 2)) - 32'd1;
            default: begin
               off = $urandom_range(0, 1 << $urandom_range(1, 24));
               f.prior[i] = $urandom_range(0, 1) ? f.tip[i] - off : f.tip[i] + off;
            end
         endcase
      end
      f.shrinking = ($urandom_range(0, 9) == 0);
      f.length = $urandom;
      f.seg = $urandom;
      f.pole = $urandom;
      return f;
   endfunction

   function automatic filament_type make_filament(input logic [31:0] tx, ty, tz, px, py, pz,
                                                  input logic shr, input logic [31:0] len,
                                                  input logic [9:0] seg, input logic pole);
      filament_type f;
      f.tip[0] = tx; f.tip[1] = ty; f.tip[2] = tz;
      f.prior[0] = px; f.prior[1] = py; f.prior[2] = pz;
      f.shrinking = shr; f.length = len; f.seg = seg; f.pole = pole;
      return f;
   endfunction

   task automatic random_phase(input int count);
      for (int n = 0; n < count; n++) filament_feed.push_back(random_filament());
      drain();
   endtask

   initial begin
      reset <= 1'b1;
      start <= 1'b0;
      csr_valid <= 1'b0;
      csr_index <= mbr_pkg::CSR_SHAPE_MODE;
      csr_wdata <= '0;
      req_tip_x <= '0; req_tip_y <= '0; req_tip_z <= '0;
      req_prior_x <= '0; req_prior_y <= '0; req_prior_z <= '0;
      req_shrinking <= 1'b0; req_filament_length <= '0;
      req_segment_index <= 10'd1; req_pole_index <= 1'b0;
      cfg_box = 1'b0;
      for (int i = 0; i < 3; i++) cfg_axis[i] = mbr_pkg::AXIS_RESET;
      cfg_radius = mbr_pkg::RADIUS_RESET;
      calm = 0;
      fail_count = 0;
      stall_cycles = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed filaments against the reset membrane, a unit sphere.
      filament_feed.push_back(make_filament(0, 0, 0, 0, 0, 0, 0, 32'h10000, 1, 0));
      filament_feed.push_back(make_filament(32'h2000, 0, 0, 32'h1000, 0, 0, 0,
                                            32'h10000, 1, 1));
      filament_feed.push_back(make_filament(32'h2000, 0, 0, 32'h1000, 0, 0, 1,
                                            32'h10000, 5, 1));
      filament_feed.push_back(make_filament(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                                            32'h80000000, 32'h80000000, 32'h80000000, 0,
                                            32'h7fffffff, 10'd1023, 1));
      filament_feed.push_back(make_filament(32'h80000000, 32'h80000000, 32'h80000000,
                                            32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0,
                                            32'h80000000, 10'd0, 0));
      filament_feed.push_back(make_filament(32'h3000, 32'hffffd000, 32'h3000, 32'h3001,
                                            32'hffffd001, 32'h2fff, 0, 32'h0, 2, 0));
      filament_feed.push_back(make_filament(32'h3000, 32'h3000, 32'h3000, 32'h3000,
                                            32'h3000, 32'h3000, 0, 32'h5000, 3, 1));
      filament_feed.push_back(make_filament(32'h1000, 0, 0, 0, 0, 0, 0, 1, 1, 0));
      filament_feed.push_back(make_filament(32'h1001, 0, 0, 0, 0, 0, 0, 1, 1, 0));
      filament_feed.push_back(make_filament(0, 32'hffffefff, 0, 0, 0, 0, 0, 1, 1, 1));
      filament_feed.push_back(make_filament(0, 0, 32'h00001001, 0, 0, 32'h5000, 0,
                                            32'hffffffff, 10'd512, 0));
      drain();
      random_phase(300);

      // Box membrane, directed filaments checked against its faces.
      write_reg(mbr_pkg::CSR_SHAPE_MODE, 32'd1);
      filament_feed.push_back(make_filament(32'h800, 0, 0, 0, 0, 0, 0, 32'h8000, 1, 0));
      filament_feed.push_back(make_filament(32'h801, 0, 0, 0, 0, 0, 0, 32'h8000, 1, 0));
      filament_feed.push_back(make_filament(0, 32'hfffff7ff, 0, 0, 0, 0, 0, 32'h8000, 4, 1));
      filament_feed.push_back(make_filament(0, 0, 32'h7fffffff, 0, 0, 32'h80000000, 0,
                                            32'h80000000, 10'd1023, 1));
      drain();
      random_phase(250);

      // Tiny membrane and the widest tube: nearly every tip is outside.
      write_reg(mbr_pkg::CSR_AXIS_A, 32'd1);
      write_reg(mbr_pkg::CSR_AXIS_B, 32'd1);
      write_reg(mbr_pkg::CSR_AXIS_C, 32'd1);
      write_reg(mbr_pkg::CSR_TUBE_RADIUS, 32'h7fffffff);
      calm = 1;
      random_phase(250);
      calm = 0;
      write_reg(mbr_pkg::CSR_SHAPE_MODE, 32'd0);
      random_phase(250);

      // Largest membrane, zero tube radius.
      write_reg(mbr_pkg::CSR_AXIS_A, 32'h7fffffff);
      write_reg(mbr_pkg::CSR_AXIS_B, 32'h7fffffff);
      write_reg(mbr_pkg::CSR_AXIS_C, 32'h7fffffff);
      write_reg(mbr_pkg::CSR_TUBE_RADIUS, 32'd0);
      random_phase(250);

      // Uneven ellipsoid and box with random extents.
      write_reg(mbr_pkg::CSR_AXIS_A, $urandom_range(1, 32'h100000));
      write_reg(mbr_pkg::CSR_AXIS_B, $urandom_range(1, 32'h1000000));
      write_reg(mbr_pkg::CSR_AXIS_C, $urandom_range(1, 32'h10000));
      write_reg(mbr_pkg::CSR_TUBE_RADIUS, $urandom_range(0, 32'h40000));
      random_phase(300);
      write_reg(mbr_pkg::CSR_SHAPE_MODE, 32'd1);
      write_reg(mbr_pkg::CSR_TUBE_RADIUS, $urandom);
      random_phase(300);

      if (fail_count == 0)
         $display("membrane_boundary_retract_core_tb OK");
      else
         $display("membrane_boundary_retract_core_tb NOT OK");
      $finish;
   end

   always @(posedge clock) begin
      if (rsp_valid === 1'bx && !reset) begin
         $error("rsp_valid unknown");
         fail_count++;
      end
   end

endmodule
